// ----- src/qte_pkg.sv -----
// Shared constants, widths and the arctangent table for the quaternion to Euler angle
// converter. No dependencies.
package qte_pkg;

    localparam int QUAT_W        = 15;
    localparam int QUAT_FRAC     = 14;
    localparam int OUT_W         = 16;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 1;
    localparam int PROD_W        = 2 * QUAT_W;
    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int NST           = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int ANG_FRAC      = 20;
    localparam int ANG_W         = 32;
    localparam int DP_W          = 36;   // CORDIC x/y datapath
    localparam int NORM_BIT      = 29;
    localparam int RAD_SHIFT     = 20;
    localparam int RAD_SRC_W     = 2 * QUAT_FRAC + 3;
    localparam int RAD_W         = RAD_SRC_W + RAD_SHIFT + 1;
    localparam int SQ_STEPS      = RAD_W / 2;
    localparam int NORM_STEPS    = 5;
    localparam int LANES         = 3;
    localparam int LANE_ROLL     = 0;
    localparam int LANE_PITCH    = 1;
    localparam int LANE_YAW      = 2;
    // products, operands, root steps, shift steps, half-turn, CORDIC, output
    localparam int PIPE_LEN      = 2 + SQ_STEPS + NORM_STEPS + 1 + NST + 1;

    localparam logic signed [DP_W-1:0]  ONE_Q   = DP_W'(64'sd1 << (2 * QUAT_FRAC));
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 << ANG_FRAC);
    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 << ANG_FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_OFFSET  = 1'b0,
        CFG_PITCH_OFFSET = 1'b1
    } cfg_idx_t;

    typedef logic signed [DP_W-1:0]  dp_t;
    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic [RAD_W-1:0]        rad_t;

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    function automatic ang_t atan_entry(input int i);
        ang_t a;
        case (i)
            0:       a = 47185920;
            1:       a = 27855475;
            2:       a = 14718068;
            3:       a = 7471121;
            4:       a = 3750058;
            5:       a = 1876857;
            6:       a = 938658;
            7:       a = 469357;
            8:       a = 234682;
            9:       a = 117342;
            10:      a = 58671;
            11:      a = 29335;
            12:      a = 14668;
            13:      a = 7334;
            14:      a = 3667;
            15:      a = 1833;
            16:      a = 917;
            17:      a = 458;
            18:      a = 229;
            19:      a = 115;
            20:      a = 57;
            21:      a = 29;
            22:      a = 14;
            23:      a = 7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/quaternion_to_euler_angles.sv -----
// Quaternion to roll/pitch/yaw converter: products, two pipelined square roots,
// normalising shifter and three unrolled CORDIC lanes. Depends on qte_pkg.
//
// Usage:
//   s_ channel: one unit quaternion per transfer, four signed Q1.14 words.
//   m_ channel: roll, pitch and yaw in signed 1/128 degree, one result per input.
//   cfg channel: roll_offset (index 0) and pitch_offset (index 1), always ready;
//   write only while no quaternion is in flight.
// Timing:
//   The pipeline is one product stage, one operand stage, 26 root steps,
//   5 shift steps, a half-turn stage, the CORDIC stages (16 here) and the
//   output register.
//   Throughput is one quaternion per cycle while no stall holds it; each
//   root, shift or CORDIC stage is one root step, one shift or one rotation.
// Reset:
//   aresetn clears all valid bits, roll_offset to 0 and pitch_offset to 1.5 deg.
// Stall:
//   while a result waits on m_tready the whole pipeline holds and s_tready is
//   low; nothing is dropped or repeated, and empty slots move on with it.
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // quat_real[14:0], quat_i[29:15], quat_j[44:30], quat_k[59:45], zero pad
    input  logic [63:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // roll_deg[15:0], pitch_deg[31:16], yaw_deg[47:32]
    output logic [47:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic                    adv;
    logic [PIPE_LEN-1:0]     vld_reg;
    logic signed [CFG_W-1:0] roll_off_reg;
    logic signed [CFG_W-1:0] pitch_off_reg;

    assign adv       = !vld_reg[PIPE_LEN-1] || m_tready;
    assign s_tready  = adv;
    assign m_tvalid  = vld_reg[PIPE_LEN-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_off_reg  <= '0;
            pitch_off_reg <= CFG_W'(192);
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROLL_OFFSET:  roll_off_reg  <= cfg_data;
                CFG_PITCH_OFFSET: pitch_off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // ---- products
    logic signed [QUAT_W-1:0] qr, qi, qj, qk;
    logic signed [PROD_W-1:0] prod_reg [9];

    assign qr = s_tdata[QUAT_W-1:0];
    assign qi = s_tdata[2*QUAT_W-1:QUAT_W];
    assign qj = s_tdata[3*QUAT_W-1:2*QUAT_W];
    assign qk = s_tdata[4*QUAT_W-1:3*QUAT_W];

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= qr * qi;
            prod_reg[1] <= qj * qk;
            prod_reg[2] <= qi * qi;
            prod_reg[3] <= qj * qj;
            prod_reg[4] <= qk * qk;
            prod_reg[5] <= qr * qk;
            prod_reg[6] <= qi * qj;
            prod_reg[7] <= qr * qj;
            prod_reg[8] <= qi * qk;
        end
    end

    // ---- operands: roll y/x, yaw y/x, and the two clamped radicands
    dp_t  pe [9];
    dp_t  s_term, rp, rm;
    dp_t  ops_next [4];
    rad_t radp_next, radm_next;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            pe[n] = DP_W'(prod_reg[n]);
        end
        ops_next[0] = (pe[0] + pe[1]) <<< 1;
        ops_next[1] = ONE_Q - ((pe[2] + pe[3]) <<< 1);
        ops_next[2] = (pe[5] + pe[6]) <<< 1;
        ops_next[3] = ONE_Q - ((pe[3] + pe[4]) <<< 1);
        s_term      = pe[7] - pe[8];
        rp          = ONE_Q + (s_term <<< 1);
        rm          = ONE_Q - (s_term <<< 1);
        radp_next   = rp[DP_W-1] ? '0 : (RAD_W'(rp[RAD_SRC_W-1:0]) << RAD_SHIFT);
        radm_next   = rm[DP_W-1] ? '0 : (RAD_W'(rm[RAD_SRC_W-1:0]) << RAD_SHIFT);
    end

    // ---- square roots, one step per stage; roll/yaw operands ride alongside
    rad_t sqv_reg [2][SQ_STEPS+1];
    rad_t sqr_reg [2][SQ_STEPS+1];
    dp_t  ops_reg [SQ_STEPS+1][4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqv_reg[0][0] <= radp_next;
            sqv_reg[1][0] <= radm_next;
            sqr_reg[0][0] <= '0;
            sqr_reg[1][0] <= '0;
            for (int n = 0; n < 4; n++) begin
                ops_reg[0][n] <= ops_next[n];
            end
        end
    end

    for (genvar st = 0; st < SQ_STEPS; st++) begin : g_sqrt
        localparam rad_t BIT = RAD_W'(1) << (2 * (SQ_STEPS - 1 - st));
        for (genvar h = 0; h < 2; h++) begin : g_half
            rad_t trial;
            assign trial = sqr_reg[h][st] + BIT;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (sqv_reg[h][st] >= trial) begin
                        sqv_reg[h][st+1] <= sqv_reg[h][st] - trial;
                        sqr_reg[h][st+1] <= (sqr_reg[h][st] >> 1) + BIT;
                    end else begin
                        sqv_reg[h][st+1] <= sqv_reg[h][st];
                        sqr_reg[h][st+1] <= sqr_reg[h][st] >> 1;
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int n = 0; n < 4; n++) begin
                    ops_reg[st+1][n] <= ops_reg[st][n];
                end
            end
        end
    end

    // ---- normalising shift (16, 8, 4, 2, 1), lanes roll / pitch / yaw
    dp_t  nx_in [LANES];
    dp_t  ny_in [LANES];
    logic nz_in [LANES];
    dp_t  nx_reg [NORM_STEPS][LANES];
    dp_t  ny_reg [NORM_STEPS][LANES];
    logic nz_reg [NORM_STEPS][LANES];

    assign ny_in[LANE_ROLL]  = ops_reg[SQ_STEPS][0];
    assign nx_in[LANE_ROLL]  = ops_reg[SQ_STEPS][1];
    assign ny_in[LANE_PITCH] = DP_W'(sqr_reg[0][SQ_STEPS]);
    assign nx_in[LANE_PITCH] = DP_W'(sqr_reg[1][SQ_STEPS]);
    assign ny_in[LANE_YAW]   = ops_reg[SQ_STEPS][2];
    assign nx_in[LANE_YAW]   = ops_reg[SQ_STEPS][3];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign nz_in[l] = (nx_in[l] == '0) && (ny_in[l] == '0);

        for (genvar st = 0; st < NORM_STEPS; st++) begin : g_norm
            localparam int  SH  = 16 >> st;
            localparam dp_t THR = DP_W'(1) << (NORM_BIT - SH);
            dp_t  x0, y0;
            logic z0;
            logic shift_ok;
            if (st == 0) begin : g_first
                assign x0 = nx_in[l];
                assign y0 = ny_in[l];
                assign z0 = nz_in[l];
            end else begin : g_later
                assign x0 = nx_reg[st-1][l];
                assign y0 = ny_reg[st-1][l];
                assign z0 = nz_reg[st-1][l];
            end
            assign shift_ok = (x0 < THR) && (x0 > -THR) && (y0 < THR) && (y0 > -THR);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    nx_reg[st][l] <= shift_ok ? (x0 <<< SH) : x0;
                    ny_reg[st][l] <= shift_ok ? (y0 <<< SH) : y0;
                    nz_reg[st][l] <= z0;
                end
            end
        end
    end

    // ---- last single shift, then half turn for negative x; CORDIC lanes
    dp_t  cx_reg [NST+1][LANES];
    dp_t  cy_reg [NST+1][LANES];
    ang_t ca_reg [NST+1][LANES];
    logic cz_reg [NST+1][LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_turn
        localparam dp_t LIM = DP_W'(1) << NORM_BIT;
        logic shift_ok;
        dp_t  x1, y1;
        assign shift_ok = (nx_reg[NORM_STEPS-1][l] < LIM) && (nx_reg[NORM_STEPS-1][l] > -LIM)
                       && (ny_reg[NORM_STEPS-1][l] < LIM) && (ny_reg[NORM_STEPS-1][l] > -LIM);
        assign x1 = shift_ok ? (nx_reg[NORM_STEPS-1][l] <<< 1) : nx_reg[NORM_STEPS-1][l];
        assign y1 = shift_ok ? (ny_reg[NORM_STEPS-1][l] <<< 1) : ny_reg[NORM_STEPS-1][l];
        always_ff @(posedge aclk) begin
            if (adv) begin
                cz_reg[0][l] <= nz_reg[NORM_STEPS-1][l];
                if (x1[DP_W-1]) begin
                    cx_reg[0][l] <= -x1;
                    cy_reg[0][l] <= -y1;
                    ca_reg[0][l] <= y1[DP_W-1] ? -ANG_180 : ANG_180;
                end else begin
                    cx_reg[0][l] <= x1;
                    cy_reg[0][l] <= y1;
                    ca_reg[0][l] <= '0;
                end
            end
        end

        for (genvar st = 0; st < NST; st++) begin : g_cordic
            localparam ang_t ATN = atan_entry(st);
            dp_t xs, ys;
            assign xs = cx_reg[st][l] >>> st;
            assign ys = cy_reg[st][l] >>> st;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    cz_reg[st+1][l] <= cz_reg[st][l];
                    if (!cy_reg[st][l][DP_W-1]) begin
                        cx_reg[st+1][l] <= cx_reg[st][l] + ys;
                        cy_reg[st+1][l] <= cy_reg[st][l] - xs;
                        ca_reg[st+1][l] <= ca_reg[st][l] + ATN;
                    end else begin
                        cx_reg[st+1][l] <= cx_reg[st][l] - ys;
                        cy_reg[st+1][l] <= cy_reg[st][l] + xs;
                        ca_reg[st+1][l] <= ca_reg[st][l] - ATN;
                    end
                end
            end
        end
    end

    // ---- round to 1/128 degree, subtract offset, saturate
    function automatic logic [OUT_W-1:0] finish(input ang_t a, input logic signed [CFG_W-1:0] off);
        ang_t v;
        v = ((a + ANG_W'(4096)) >>> 13) - ANG_W'(off);
        if (v > ANG_W'(32767)) begin
            v = ANG_W'(32767);
        end else if (v < -ANG_W'(32768)) begin
            v = -ANG_W'(32768);
        end
        return v[OUT_W-1:0];
    endfunction

    ang_t        roll_a, pitch_a, yaw_a;
    logic [47:0] m_tdata_reg;

    assign roll_a  = cz_reg[NST][LANE_ROLL]  ? '0 : ca_reg[NST][LANE_ROLL];
    assign yaw_a   = cz_reg[NST][LANE_YAW]   ? '0 : ca_reg[NST][LANE_YAW];
    assign pitch_a = (cz_reg[NST][LANE_PITCH] ? '0 : (ca_reg[NST][LANE_PITCH] <<< 1)) - ANG_90;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {finish(yaw_a, '0), finish(pitch_a, pitch_off_reg),
                            finish(roll_a, roll_off_reg)};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule
